[rtl/evad_pkg.sv]
// ----------------------------------------------------------------------------
// evad_pkg
// Shared widths, constants and command/status types of the energy VAD.
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int MaxFrame    = 4096;
    localparam int CountW      = $clog2(MaxFrame + 1);
    localparam int SumW        = 30 + CountW;
    localparam int QuotW       = SumW + 2;
    localparam int RootW       = (QuotW + 1) / 2;
    localparam int DivCntW     = $clog2(QuotW + 1);
    localparam int SqrtCntW    = $clog2(RootW + 1);
    localparam int LogW        = 24;
    localparam int ExpW        = 6;

    localparam logic [63:0] DbScale = 64'd50504453;
    localparam logic signed [15:0] DbFloor = -16'sd25600;

    localparam logic [15:0] ThresholdReset = 16'hD800;
    localparam logic [7:0]  HangoverReset  = 8'd5;

    localparam logic CfgThreshold = 1'b0;
    localparam logic CfgHangover  = 1'b1;

    typedef struct packed {
        logic accum;
        logic start;
        logic div_step;
        logic sqrt_step;
        logic log_load_s;
        logic log_load_n;
        logic log_step;
        logic mul_step;
        logic finish;
        logic clear;
    } evad_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic log_done;
    } evad_sts_t;

endpackage

[rtl/evad_ctrl.sv]
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: accumulate, then divide, square root, two logarithms, scale.
// ----------------------------------------------------------------------------
module evad_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_last,
    output logic                m_tvalid,
    input  logic                m_tready,
    output evad_pkg::evad_cmd_t cmd,
    input  evad_pkg::evad_sts_t sts
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SQRT = 8'b0000_0100,
        ST_LOGS = 8'b0000_1000,
        ST_LOGN = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_FIN  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accum = 1'b1;
                    if (s_last) state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!sts.div_done) cmd.div_step = 1'b1;
                else begin
                    state_next = ST_SQRT;
                    cmd.start = 1'b1;
                end
            end
            ST_SQRT: begin
                if (!sts.sqrt_done) cmd.sqrt_step = 1'b1;
                else begin
                    state_next = ST_LOGS;
                    cmd.log_load_s = 1'b1;
                end
            end
            ST_LOGS: begin
                if (!sts.log_done) cmd.log_step = 1'b1;
                else begin
                    state_next = ST_LOGN;
                    cmd.log_load_n = 1'b1;
                end
            end
            ST_LOGN: begin
                if (!sts.log_done) cmd.log_step = 1'b1;
                else begin
                    state_next = ST_MUL;
                    cmd.mul_step = 1'b1;
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

[rtl/evad_datapath.sv]
// ----------------------------------------------------------------------------
// evad_datapath
// Accumulators, restoring divider, bit-pair square root, squaring log2 unit,
// dB scaling and hangover decision.
// ----------------------------------------------------------------------------
module evad_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic signed [15:0]  sample,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic                cfg_valid_index,
    input  logic [15:0]         cfg_wr_data,
    input  evad_pkg::evad_cmd_t cmd,
    output evad_pkg::evad_sts_t sts,
    output logic [16:0]         rms_level,
    output logic signed [15:0]  level_db,
    output logic                voiced,
    output logic                frame_overflow
);

    localparam int SumW   = evad_pkg::SumW;
    localparam int QuotW  = evad_pkg::QuotW;
    localparam int RootW  = evad_pkg::RootW;
    localparam int CountW = evad_pkg::CountW;
    localparam int LogW   = evad_pkg::LogW;

    logic signed [15:0] threshold_reg;
    logic [7:0]         hangover_frames_reg;
    logic [7:0]         hangover_left_reg;
    logic [SumW-1:0]    energy_reg;
    logic [CountW-1:0]  count_reg;
    logic               overflow_reg;

    logic [QuotW-1:0]   rem_div_reg;
    logic [QuotW-1:0]   quot_reg;
    logic [evad_pkg::DivCntW-1:0]  div_cnt_reg;
    logic [QuotW+1:0]   sq_x_reg;
    logic [QuotW+1:0]   sq_root_reg;
    logic [evad_pkg::SqrtCntW-1:0] sq_cnt_reg;
    logic [31:0]        mant_reg;
    logic [4:0]         log_cnt_reg;
    logic [LogW-1:0]    log_acc_reg;
    logic [LogW-1:0]    log_s_reg;
    logic signed [63:0] prod_reg;
    logic [16:0]        rms_reg;
    logic signed [15:0] level_reg;
    logic               voiced_reg;
    logic               ovf_out_reg;

    logic [15:0]        mag;
    logic [31:0]        sq;
    logic [QuotW:0]     rem_try;
    logic [QuotW+1:0]   sq_try;
    logic [63:0]        msq;
    logic [32:0]        mnext;
    logic [SumW-1:0]    log_src;
    logic [evad_pkg::ExpW-1:0] msb;
    logic [31:0]        mant_init;
    logic signed [LogW:0] dlog;
    logic signed [63:0] prod_abs;
    logic signed [63:0] lvl;
    logic signed [15:0] lvl_sat;

    assign mag = sample[15] ? 16'(-sample) : 16'(sample);
    assign sq  = mag * mag;

    // restoring divide of 4*S by N, one quotient bit a cycle
    assign rem_try = {rem_div_reg, quot_reg[QuotW-1]} - (QuotW+1)'(count_reg);
    // bit-pair square root
    assign sq_try = sq_x_reg - (sq_root_reg | (QuotW+2)'(1) << (2 * (sq_cnt_reg - 1)));

    always_comb begin
        log_src = cmd.log_load_s ? energy_reg : SumW'(count_reg);
        msb = '0;
        for (int i = 0; i < SumW; i++) begin
            if (log_src[i]) msb = evad_pkg::ExpW'(i);
        end
        if (msb >= 30) mant_init = 32'(log_src >> (msb - 30));
        else           mant_init = 32'(log_src << (30 - msb));
    end

    assign msq   = mant_reg * mant_reg;
    assign mnext = 33'(msq >> 30);

    assign dlog = $signed({1'b0, log_s_reg}) - $signed({1'b0, log_acc_reg})
                  - (LogW+1)'(30 * 65536);
    assign prod_abs = prod_reg < 0 ? -prod_reg : prod_reg;

    always_comb begin
        lvl = (prod_abs + 64'sd2147483648) >>> 32;
        if (prod_reg < 0) lvl = -lvl;
        if (energy_reg == '0 || lvl < 64'(evad_pkg::DbFloor)) lvl_sat = evad_pkg::DbFloor;
        else if (lvl > 0) lvl_sat = '0;
        else lvl_sat = 16'(lvl);
    end

    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.sqrt_done = (sq_cnt_reg == '0) && sq_root_reg[QuotW+1];
    assign sts.log_done  = (log_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg       <= evad_pkg::ThresholdReset;
            hangover_frames_reg <= evad_pkg::HangoverReset;
            hangover_left_reg   <= '0;
            energy_reg          <= '0;
            count_reg           <= '0;
            overflow_reg        <= 1'b0;
            div_cnt_reg         <= evad_pkg::DivCntW'(QuotW + 1);
            sq_cnt_reg          <= '0;
            sq_root_reg         <= '0;
            log_cnt_reg         <= '0;
        end else begin
            if (cfg_wr_en && cfg_valid_index) begin
                if (cfg_index == evad_pkg::CfgThreshold) threshold_reg <= cfg_wr_data;
                else hangover_frames_reg <= cfg_wr_data[7:0];
            end
            if (cmd.accum) begin
                if (count_reg < CountW'(evad_pkg::MaxFrame)) begin
                    energy_reg <= energy_reg + SumW'(sq);
                    count_reg  <= count_reg + 1'b1;
                end else overflow_reg <= 1'b1;
                rem_div_reg <= '0;
                quot_reg    <= '0;
                div_cnt_reg <= evad_pkg::DivCntW'(QuotW + 1);
            end
            if (cmd.div_step) begin
                if (div_cnt_reg == evad_pkg::DivCntW'(QuotW + 1))
                    quot_reg <= {energy_reg, 2'b00};
                else begin
                    if (!rem_try[QuotW]) begin
                        rem_div_reg <= rem_try[QuotW-1:0];
                        quot_reg    <= {quot_reg[QuotW-2:0], 1'b1};
                    end else begin
                        rem_div_reg <= {rem_div_reg[QuotW-2:0], quot_reg[QuotW-1]};
                        quot_reg    <= {quot_reg[QuotW-2:0], 1'b0};
                    end
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.start) begin
                sq_x_reg    <= (QuotW+2)'(quot_reg);
                sq_root_reg <= '0;
                sq_cnt_reg  <= evad_pkg::SqrtCntW'(RootW);
            end
            if (cmd.sqrt_step) begin
                if (sq_cnt_reg != '0) begin
                    if (!sq_try[QuotW+1]) begin
                        sq_x_reg    <= sq_try;
                        sq_root_reg <= (sq_root_reg >> 1) | ((QuotW+2)'(1) << (2 * (sq_cnt_reg - 1)));
                    end else sq_root_reg <= sq_root_reg >> 1;
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                end else begin
                    rms_reg <= 17'(sq_root_reg);
                    sq_root_reg[QuotW+1] <= 1'b1;
                end
            end
            if (cmd.log_load_s || cmd.log_load_n) begin
                if (cmd.log_load_n) log_s_reg <= log_acc_reg;
                mant_reg    <= mant_init;
                log_acc_reg <= LogW'(msb);
                log_cnt_reg <= 5'd16;
            end
            if (cmd.log_step) begin
                mant_reg    <= mnext[31] ? mnext[32:1] : mnext[31:0];
                log_acc_reg <= {log_acc_reg[LogW-2:0], mnext[31]};
                log_cnt_reg <= log_cnt_reg - 1'b1;
            end
            if (cmd.mul_step) prod_reg <= 64'(dlog) * $signed(evad_pkg::DbScale);
            if (cmd.finish) begin
                level_reg   <= lvl_sat;
                ovf_out_reg <= overflow_reg;
                if (lvl_sat > threshold_reg) begin
                    hangover_left_reg <= hangover_frames_reg;
                    voiced_reg <= 1'b1;
                end else if (hangover_left_reg != '0) begin
                    hangover_left_reg <= hangover_left_reg - 1'b1;
                    voiced_reg <= 1'b1;
                end else voiced_reg <= 1'b0;
            end
            if (cmd.clear) begin
                energy_reg   <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                sq_root_reg  <= '0;
            end
        end
    end

    assign rms_level      = rms_reg;
    assign level_db       = level_reg;
    assign voiced         = voiced_reg;
    assign frame_overflow = ovf_out_reg;

endmodule

[rtl/energy_voice_activity_detector_unit.sv]
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit
// Frame energy VAD with hangover.
// ----------------------------------------------------------------------------
// One sample beat is taken per cycle while a frame is accumulating. The beat
// carrying tlast closes the frame; the result beat is then computed by a
// one-bit-a-cycle divider (a load step and 45 steps), a two-bit-a-cycle square
// root (23 steps) and two 16-step log2 passes, with hand-over states between
// them. No new sample is taken until the result beat has been delivered.
module energy_voice_activity_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // last_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] rms_level, [32:17] level_db
    output logic [1:0]  m_tuser,   // [0] voiced, [1] frame_overflow
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    evad_pkg::evad_cmd_t cmd;
    evad_pkg::evad_sts_t sts;
    logic [16:0]        rms_level;
    logic signed [15:0] level_db;
    logic               voiced;
    logic               frame_overflow;

    evad_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_last(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    evad_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .sample(s_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index[0]), .cfg_valid_index(1'b1),
        .cfg_wr_data(cfg_wr_data),
        .cmd(cmd), .sts(sts),
        .rms_level(rms_level), .level_db(level_db),
        .voiced(voiced), .frame_overflow(frame_overflow)
    );

    assign m_tdata = {7'd0, level_db, rms_level};
    assign m_tuser = {frame_overflow, voiced};

endmodule

[rtl/evad_checker.sv]
// ----------------------------------------------------------------------------
// evad_checker
// Port-level checks of the energy VAD.
// ----------------------------------------------------------------------------
module evad_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("frame close ignored");

    a_db_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32] || (m_tdata[32:17] == 16'd0))
        else $error("level above 0 dB");

endmodule

bind energy_voice_activity_detector_unit evad_checker u_evad_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[dv/energy_voice_activity_detector_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit_tb
// Streams framed audio samples into the energy VAD, predicts RMS, dB level,
// voiced decision and overflow flag per frame, and checks every result beat.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_unit_tb;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } sample_beat_t;

    typedef struct packed {
        logic [16:0] rms;
        logic [15:0] db;
        logic        voiced;
        logic        ovf;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_wr_data = '0;

    energy_voice_activity_detector_unit u_dut (.*);

    always #6 aclk = ~aclk;

    sample_beat_t  pending_samples[$];
    frame_result_t expected_frames[$];
    int  fail_count = 0;
    int  idle_pct = 37;
    int  hold_cycles = 0;
    bit  hold_req = 1'b0;

    logic signed [15:0] thr_db;
    logic [7:0]         hang_frames;
    logic [63:0]        acc_energy;
    int unsigned        acc_count;
    int unsigned        hang_left;
    bit                 acc_ovf;

    function automatic logic [31:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= root + bit_v) begin
                x = x - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root[31:0];
    endfunction

    function automatic longint log2_fix(input logic [63:0] x);
        int e;
        logic [127:0] m;
        longint frac;
        e = 63;
        frac = 0;
        while (x[e] == 1'b0) e--;
        if (e >= 30) m = x >> (e - 30);
        else m = x << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (128'd1 << 31)) begin
                m >>= 1;
                frac |= 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic int frame_db(input logic [63:0] sum, input int unsigned n);
        longint d, p, lvl;
        if (sum == 0) return -25600;
        d = log2_fix(sum) - log2_fix(64'(n)) - (longint'(30) << 16);
        p = d * 64'sd50504453;
        if (p < 0) lvl = -((-p + (longint'(1) << 31)) >>> 32);
        else lvl = (p + (longint'(1) << 31)) >>> 32;
        if (lvl < -25600) lvl = -25600;
        if (lvl > 0) lvl = 0;
        return int'(lvl);
    endfunction

    task automatic predict_sample(input sample_beat_t b);
        int s;
        int lvl;
        frame_result_t r;
        s = int'($signed(b.sample));
        if (acc_count < evad_pkg::MaxFrame) begin
            acc_energy += 64'(s * s);
            acc_count++;
        end else begin
            acc_ovf = 1'b1;
        end
        if (!b.last) return;
        lvl = frame_db(acc_energy, acc_count);
        r.rms = 17'(int_sqrt((acc_energy * 4) / acc_count));
        r.db = lvl[15:0];
        if (lvl > int'(thr_db)) begin
            hang_left = hang_frames;
            r.voiced = 1'b1;
        end else if (hang_left > 0) begin
            hang_left--;
            r.voiced = 1'b1;
        end else begin
            r.voiced = 1'b0;
        end
        r.ovf = acc_ovf;
        expected_frames.push_back(r);
        acc_energy = 0;
        acc_count = 0;
        acc_ovf = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_sample({s_tdata, s_tlast});
            if (!(s_tvalid && !s_tready)) begin
                if (pending_samples.size() > 0 &&
                    $urandom_range(99, 0) >= idle_pct) begin
                    s_tdata <= pending_samples[0].sample;
                    s_tlast <= pending_samples[0].last;
                    s_tvalid <= 1'b1;
                    void'(pending_samples.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        frame_result_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], 0);
                end else begin
                    w = expected_frames.pop_front();
                    if (m_tdata[16:0] !== w.rms) report_mismatch("rms", m_tdata[16:0], w.rms);
                    if (m_tdata[32:17] !== w.db) report_mismatch("db", m_tdata[32:17], w.db);
                    if (m_tuser[0] !== w.voiced) report_mismatch("voiced", m_tuser[0], w.voiced);
                    if (m_tuser[1] !== w.ovf) report_mismatch("overflow", m_tuser[1], w.ovf);
                end
            end
            if (hold_req && hold_cycles == 0) hold_cycles = 600;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == evad_pkg::CfgThreshold) thr_db = val;
        else hang_frames = val[7:0];
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_tvalid || expected_frames.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_frame(input int len, input int kind);
        sample_beat_t b;
        int amp;
        amp = 1 << $urandom_range(15, 0);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: b.sample = 16'($urandom);
                1: b.sample = 16'($signed($urandom_range(2 * amp, 0)) - amp);
                2: b.sample = 16'h0000;
                default: b.sample = $urandom_range(1, 0) ? 16'h8000 : 16'h7fff;
            endcase
            b.last = (i == len - 1);
            pending_samples.push_back(b);
        end
    endtask

    initial begin
        sample_beat_t b;
        int n;
        thr_db = -16'sd10240;
        hang_frames = 8'd5;
        acc_energy = 0;
        acc_count = 0;
        hang_left = 0;
        acc_ovf = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: silence, full scale, single samples, mixed
        b = '{16'h0000, 1'b1}; pending_samples.push_back(b);
        b = '{16'h8000, 1'b1}; pending_samples.push_back(b);
        b = '{16'h7fff, 1'b1}; pending_samples.push_back(b);
        b = '{16'h0001, 1'b1}; pending_samples.push_back(b);
        b = '{16'hffff, 1'b1}; pending_samples.push_back(b);
        push_frame(4, 3);
        push_frame(3, 2);
        push_frame(5, 0);
        drain();
        write_reg(evad_pkg::CfgThreshold, 16'h8000);
        write_reg(evad_pkg::CfgHangover, 16'h0000);
        push_frame(4, 1);
        push_frame(2, 2);
        drain();
        write_reg(evad_pkg::CfgThreshold, 16'h7fff);
        write_reg(evad_pkg::CfgHangover, 16'h00ff);
        push_frame(3, 0);
        push_frame(2, 2);
        drain();
        // long full-scale and mid-level frames, then sender pause until drained
        write_reg(evad_pkg::CfgThreshold, 16'hec00);
        write_reg(evad_pkg::CfgHangover, 16'h0002);
        push_frame(64, 3);
        push_frame(200, 1);
        drain();
        n = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(evad_pkg::CfgThreshold, 16'($signed($urandom_range(8000, 0)) - 20000));
            write_reg(evad_pkg::CfgHangover, 16'($urandom_range(ph == 3 ? 255 : 6, 0)));
            idle_pct = (ph == 1) ? 0 : 37;
            if (ph == 2) hold_req = 1'b1;
            while (n < 220 * (ph + 1)) begin
                int len;
                len = $urandom_range(8, 1);
                push_frame(len, $urandom_range(9, 0) < 6 ? 1 : $urandom_range(3, 0));
                n += len;
            end
            if (ph == 2) begin
                while (hold_cycles == 0) @(posedge aclk);
                hold_req = 1'b0;
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(12 * 3000000);
        $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
rtl/evad_pkg.sv
rtl/evad_ctrl.sv
rtl/evad_datapath.sv
rtl/energy_voice_activity_detector_unit.sv
rtl/evad_checker.sv
dv/energy_voice_activity_detector_unit_tb.sv
